// ===== rtl/core/sleb_pkg.sv =====
// ----------------------------------------------------------------------------
// sleb_pkg
// Shared types and codes of the status LED error-code blinker: item payloads,
// configuration bundle, controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package sleb_pkg;

  // Event kinds carried in the mode field
  localparam logic [2:0] MODE_TICK  = 3'd0;
  localparam logic [2:0] MODE_SET   = 3'd1;
  localparam logic [2:0] MODE_ACT   = 3'd2;
  localparam logic [2:0] MODE_DEACT = 3'd3;
  localparam logic [2:0] MODE_CLEAR = 3'd4;

  // Display states
  localparam logic [2:0] ST_OFF     = 3'd0;
  localparam logic [2:0] ST_INIT    = 3'd1;
  localparam logic [2:0] ST_RUN     = 3'd2;
  localparam logic [2:0] ST_ERROR   = 3'd3;
  localparam logic [2:0] ST_WARNING = 3'd4;

  // Shown colors
  localparam logic [2:0] K_OFF     = 3'd0;
  localparam logic [2:0] K_INIT    = 3'd1;
  localparam logic [2:0] K_RUN     = 3'd2;
  localparam logic [2:0] K_WARNING = 3'd3;
  localparam logic [2:0] K_BLINK   = 3'd4;

  // Register indexes
  localparam logic [2:0] REG_SHORT_PULSE = 3'd0;
  localparam logic [2:0] REG_LONG_PULSE  = 3'd1;
  localparam logic [2:0] REG_BIT_GAP     = 3'd2;
  localparam logic [2:0] REG_CODE_GAP    = 3'd3;
  localparam logic [2:0] REG_SLOT_A      = 3'd4;
  localparam logic [2:0] REG_SLOT_B      = 3'd5;
  localparam logic [2:0] REG_SLOT_C      = 3'd6;
  localparam logic [2:0] REG_SLOT_D      = 3'd7;

  localparam int SLOT_NUM = 4;
  localparam int SLOT_W   = 47;
  localparam int PATTERN_SLOTS = 4;
  localparam logic [5:0] MAX_PATTERN_BITS = 6'd32;

  localparam logic [15:0] SHORT_PULSE_RST = 16'd200;
  localparam logic [15:0] LONG_PULSE_RST  = 16'd600;
  localparam logic [15:0] BIT_GAP_RST     = 16'd200;
  localparam logic [15:0] CODE_GAP_RST    = 16'd1500;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] error_code;
    logic [2:0] new_state;
  } sleb_in_t;

  typedef struct packed {
    logic [2:0] color_kind;
    logic       color_written;
    logic [2:0] display_state;
    logic [3:0] codes_active;
  } sleb_out_t;

  typedef struct packed {
    logic [15:0]                        short_pulse_ms;
    logic [15:0]                        long_pulse_ms;
    logic [15:0]                        bit_gap_ms;
    logic [15:0]                        code_gap_ms;
    logic [SLOT_NUM-1:0][SLOT_W-1:0]    slot;
  } sleb_cfg_t;

  typedef struct packed {
    logic ld_item;
    logic tick_inc;
    logic tick_eval;
    logic lookup;
    logic pat_step;
    logic set_state;
    logic idx_clr;
    logic idx_inc;
    logic rd_next;
    logic wr_total;
    logic wr_idx;
    logic dec_total;
    logic fin_deact;
    logic clear_all;
    logic out_load;
  } sleb_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       code_zero;
    logic       blink_on;
    logic       total_zero;
    logic       idx_at_total;
    logic       list_full;
    logic       rd_match;
    logic       shift_more;
  } sleb_sts_t;

endpackage

// ===== rtl/core/status_led_error_code_blinker.sv =====
// ----------------------------------------------------------------------------
// status_led_error_code_blinker
// Drives a status LED color from millisecond ticks, state requests and error
// code activation, blinking each active code's bit pattern in turn.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one event item (tick, set state, activate,
//   deactivate, clear all). Every item yields exactly one result item on
//   out_valid/out_ready/out_data: the shown color, whether this item rewrote
//   it, the display state and the number of active codes.
//   Timing and pattern registers sit on the APB-style port (8-byte stride).
// Item handling:
//   set state and clear all go through decode and done; a tick through
//   decode and evaluation, plus RAM fetch, pattern lookup and step when
//   blinking with codes listed; activate scans the listed codes, deactivate
//   scans the codes and shifts entries down, walking the active list RAM.
//   One item is worked on at a time; the next item is taken as soon as the
//   sequencer is back in idle, while the previous result may still wait.
// Reset: state off, LED dark, no active codes, timers at default values,
//   pattern slots invalid. No clearing pass: list entries are always written
//   before they are read.
// Stall: while out_ready is low the finished result holds in the output
//   register; a following item is accepted and worked on, then holds until
//   the output register frees up.
// ----------------------------------------------------------------------------
module status_led_error_code_blinker #(
  parameter int ACTIVE_SLOTS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  // event items
  input  logic                in_valid,
  output logic                in_ready,
  input  sleb_pkg::sleb_in_t  in_data,
  // result items
  output logic                out_valid,
  input  logic                out_ready,
  output sleb_pkg::sleb_out_t out_data,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [5:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);

  sleb_pkg::sleb_cfg_t cfg_r, cfg_nxt;
  sleb_pkg::sleb_cmd_t cmd;
  sleb_pkg::sleb_sts_t sts;
  logic                cfg_wr;
  logic [2:0]          reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Register write: take the low bits of the data word for each register
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (reg_idx)
        sleb_pkg::REG_SHORT_PULSE: cfg_nxt.short_pulse_ms = pwdata[15:0];
        sleb_pkg::REG_LONG_PULSE:  cfg_nxt.long_pulse_ms  = pwdata[15:0];
        sleb_pkg::REG_BIT_GAP:     cfg_nxt.bit_gap_ms     = pwdata[15:0];
        sleb_pkg::REG_CODE_GAP:    cfg_nxt.code_gap_ms    = pwdata[15:0];
        sleb_pkg::REG_SLOT_A:      cfg_nxt.slot[0] = pwdata[sleb_pkg::SLOT_W-1:0];
        sleb_pkg::REG_SLOT_B:      cfg_nxt.slot[1] = pwdata[sleb_pkg::SLOT_W-1:0];
        sleb_pkg::REG_SLOT_C:      cfg_nxt.slot[2] = pwdata[sleb_pkg::SLOT_W-1:0];
        sleb_pkg::REG_SLOT_D:      cfg_nxt.slot[3] = pwdata[sleb_pkg::SLOT_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  // Register read-back, zero-extended to the data width
  always_comb begin
    case (reg_idx)
      sleb_pkg::REG_SHORT_PULSE: prdata = {48'd0, cfg_r.short_pulse_ms};
      sleb_pkg::REG_LONG_PULSE:  prdata = {48'd0, cfg_r.long_pulse_ms};
      sleb_pkg::REG_BIT_GAP:     prdata = {48'd0, cfg_r.bit_gap_ms};
      sleb_pkg::REG_CODE_GAP:    prdata = {48'd0, cfg_r.code_gap_ms};
      sleb_pkg::REG_SLOT_A:      prdata = {17'd0, cfg_r.slot[0]};
      sleb_pkg::REG_SLOT_B:      prdata = {17'd0, cfg_r.slot[1]};
      sleb_pkg::REG_SLOT_C:      prdata = {17'd0, cfg_r.slot[2]};
      sleb_pkg::REG_SLOT_D:      prdata = {17'd0, cfg_r.slot[3]};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_pulse_ms <= sleb_pkg::SHORT_PULSE_RST;
      cfg_r.long_pulse_ms  <= sleb_pkg::LONG_PULSE_RST;
      cfg_r.bit_gap_ms     <= sleb_pkg::BIT_GAP_RST;
      cfg_r.code_gap_ms    <= sleb_pkg::CODE_GAP_RST;
      cfg_r.slot           <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Sequencer: dispatch items and walk the list
  sleb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // State, timers, active list and result register
  sleb_dp #(
    .ACTIVE_SLOTS(ACTIVE_SLOTS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cfg     (cfg_r),
    .cmd     (cmd),
    .sts     (sts),
    .out_data(out_data)
  );

endmodule

// ===== rtl/core/sleb_ram.sv =====
// ----------------------------------------------------------------------------
// sleb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sleb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== rtl/core/sleb_ctrl.sv =====
// ----------------------------------------------------------------------------
// sleb_ctrl
// Sequencer of the blinker: dispatches each item, walks the active list and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module sleb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  sleb_pkg::sleb_sts_t sts,
  output sleb_pkg::sleb_cmd_t cmd
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_DECODE = 13'b0000000000010,
    S_TICK   = 13'b0000000000100,
    S_TREAD  = 13'b0000000001000,
    S_TSTEP  = 13'b0000000010000,
    S_ASCAN  = 13'b0000000100000,
    S_ACMP   = 13'b0000001000000,
    S_DSCAN  = 13'b0000010000000,
    S_DCMP   = 13'b0000100000000,
    S_DSHIFT = 13'b0001000000000,
    S_DMOVE  = 13'b0010000000000,
    S_DFIN   = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_item = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.mode)
          sleb_pkg::MODE_TICK: begin
            cmd.tick_inc = 1'b1;
            state_nxt    = S_TICK;
          end
          sleb_pkg::MODE_SET: begin
            cmd.set_state = 1'b1;
            state_nxt     = S_DONE;
          end
          sleb_pkg::MODE_ACT: begin
            if (sts.code_zero) begin
              state_nxt = S_DONE;
            end else begin
              cmd.idx_clr = 1'b1;
              state_nxt   = S_ASCAN;
            end
          end
          sleb_pkg::MODE_DEACT: begin
            cmd.idx_clr = 1'b1;
            state_nxt   = S_DSCAN;
          end
          sleb_pkg::MODE_CLEAR: begin
            cmd.clear_all = 1'b1;
            state_nxt     = S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_TICK: begin
        cmd.tick_eval = 1'b1;
        state_nxt     = (sts.blink_on && !sts.total_zero) ? S_TREAD : S_DONE;
      end
      S_TREAD: begin
        cmd.lookup = 1'b1;
        state_nxt  = S_TSTEP;
      end
      S_TSTEP: begin
        cmd.pat_step = 1'b1;
        state_nxt    = S_DONE;
      end
      S_ASCAN: begin
        if (sts.idx_at_total) begin
          cmd.wr_total = !sts.list_full;
          state_nxt    = S_DONE;
        end else begin
          state_nxt = S_ACMP;
        end
      end
      S_ACMP: begin
        if (sts.rd_match) begin
          state_nxt = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_ASCAN;
        end
      end
      S_DSCAN: begin
        state_nxt = sts.idx_at_total ? S_DFIN : S_DCMP;
      end
      S_DCMP: begin
        if (sts.rd_match) begin
          state_nxt = S_DSHIFT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_DSCAN;
        end
      end
      S_DSHIFT: begin
        if (sts.shift_more) begin
          cmd.rd_next = 1'b1;
          state_nxt   = S_DMOVE;
        end else begin
          cmd.dec_total = 1'b1;
          state_nxt     = S_DFIN;
        end
      end
      S_DMOVE: begin
        cmd.wr_idx = 1'b1;
        state_nxt  = S_DSHIFT;
      end
      S_DFIN: begin
        cmd.fin_deact = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/sleb_dp.sv =====
// ----------------------------------------------------------------------------
// sleb_dp
// Datapath of the blinker: display state, blink timers, cursors, active code
// list in RAM, pattern lookup and the result register.
// ----------------------------------------------------------------------------
module sleb_dp #(
  parameter int ACTIVE_SLOTS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sleb_pkg::sleb_in_t   in_data,
  input  sleb_pkg::sleb_cfg_t  cfg,
  input  sleb_pkg::sleb_cmd_t  cmd,
  output sleb_pkg::sleb_sts_t  sts,
  output sleb_pkg::sleb_out_t  out_data
);

  localparam int AW = (ACTIVE_SLOTS > 1) ? $clog2(ACTIVE_SLOTS) : 1;
  localparam int CW = $clog2(ACTIVE_SLOTS + 1);

  function automatic logic [2:0] state_kind(input logic [2:0] s);
    logic [2:0] k;
    case (s)
      sleb_pkg::ST_OFF:   k = sleb_pkg::K_OFF;
      sleb_pkg::ST_INIT:  k = sleb_pkg::K_INIT;
      sleb_pkg::ST_RUN:   k = sleb_pkg::K_RUN;
      sleb_pkg::ST_ERROR: k = sleb_pkg::K_OFF;
      default:            k = sleb_pkg::K_WARNING;
    endcase
    return k;
  endfunction

  logic [2:0]  mode_r, mode_nxt;
  logic [7:0]  code_r, code_nxt;
  logic [2:0]  ns_r, ns_nxt;
  logic [2:0]  cur_r, cur_nxt;
  logic        led_r, led_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic        written_r, written_nxt;
  logic [CW-1:0] total_r, total_nxt;
  logic [AW-1:0] ccur_r, ccur_nxt;
  logic [5:0]  bcur_r, bcur_nxt;
  logic [15:0] phase_r, phase_nxt;
  logic [15:0] toggle_r, toggle_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic        hit_r, hit_nxt;
  logic [31:0] pbits_r, pbits_nxt;
  logic [5:0]  plen_r, plen_nxt;
  sleb_pkg::sleb_out_t out_r, out_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  logic          ccur_wrap;
  logic [CW-1:0] ccur_inc;
  logic [AW-1:0] ccur_next_code;
  logic          blink_on;
  logic          at_end, bit_one;
  logic [15:0]   pulse_dur;
  logic          lk_hit;
  logic [31:0]   lk_bits;
  logic [5:0]    lk_len;
  logic [CW:0]   idx_inc1;
  logic          chg_en;
  logic [2:0]    chg_tgt;

  sleb_ram #(
    .WIDTH(8),
    .DEPTH(ACTIVE_SLOTS)
  ) u_list (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign ccur_wrap      = (CW'(ccur_r) >= total_r);
  assign ccur_inc       = CW'(ccur_r) + CW'(1);
  assign ccur_next_code = (ccur_inc >= total_r) ? '0 : AW'(ccur_inc);
  assign blink_on       = (cur_r == sleb_pkg::ST_ERROR) ||
                          ((cur_r == sleb_pkg::ST_INIT) && (total_r != '0));
  assign at_end         = (bcur_r >= plen_r);
  assign bit_one        = !at_end && pbits_r[bcur_r[4:0]];
  assign pulse_dur      = bit_one ? cfg.long_pulse_ms : cfg.short_pulse_ms;
  assign idx_inc1       = {1'b0, idx_r} + {{CW{1'b0}}, 1'b1};

  // Lowest valid slot with a matching code wins
  always_comb begin
    lk_hit  = 1'b0;
    lk_bits = '0;
    lk_len  = '0;
    for (int i = sleb_pkg::PATTERN_SLOTS - 1; i >= 0; i--) begin
      if (cfg.slot[i][46] && (cfg.slot[i][7:0] == ram_rdata)) begin
        lk_hit  = 1'b1;
        lk_bits = cfg.slot[i][45:14];
        lk_len  = (cfg.slot[i][13:8] > sleb_pkg::MAX_PATTERN_BITS) ?
                  sleb_pkg::MAX_PATTERN_BITS : cfg.slot[i][13:8];
      end
    end
  end

  always_comb begin
    mode_nxt    = mode_r;
    code_nxt    = code_r;
    ns_nxt      = ns_r;
    cur_nxt     = cur_r;
    led_nxt     = led_r;
    kind_nxt    = kind_r;
    written_nxt = written_r;
    total_nxt   = total_r;
    ccur_nxt    = ccur_r;
    bcur_nxt    = bcur_r;
    phase_nxt   = phase_r;
    toggle_nxt  = toggle_r;
    idx_nxt     = idx_r;
    hit_nxt     = hit_r;
    pbits_nxt   = pbits_r;
    plen_nxt    = plen_r;
    out_nxt     = out_r;
    ram_we      = 1'b0;
    ram_waddr   = AW'(idx_r);
    ram_wdata   = code_r;
    ram_raddr   = AW'(idx_r);
    chg_en      = 1'b0;
    chg_tgt     = sleb_pkg::ST_RUN;

    if (cmd.ld_item) begin
      mode_nxt    = in_data.mode;
      code_nxt    = in_data.error_code;
      ns_nxt      = in_data.new_state;
      written_nxt = 1'b0;
    end
    if (cmd.tick_inc) begin
      phase_nxt  = (phase_r == 16'hFFFF) ? phase_r : phase_r + 16'd1;
      toggle_nxt = (toggle_r == 16'hFFFF) ? toggle_r : toggle_r + 16'd1;
    end
    if (cmd.tick_eval && blink_on) begin
      if (total_r == '0) begin
        if (toggle_r >= cfg.short_pulse_ms) begin
          toggle_nxt  = '0;
          led_nxt     = !led_r;
          kind_nxt    = led_r ? sleb_pkg::K_OFF : sleb_pkg::K_BLINK;
          written_nxt = 1'b1;
        end
      end else begin
        // wrap a cursor left past the end by a removal, then fetch the code
        ccur_nxt  = ccur_wrap ? '0 : ccur_r;
        ram_raddr = ccur_wrap ? '0 : ccur_r;
      end
    end
    if (cmd.lookup) begin
      hit_nxt   = lk_hit;
      pbits_nxt = lk_bits;
      plen_nxt  = lk_len;
    end
    if (cmd.pat_step) begin
      if (!hit_r) begin
        ccur_nxt = ccur_next_code;
        bcur_nxt = '0;
      end else if (led_r) begin
        if (phase_r >= pulse_dur) begin
          kind_nxt    = sleb_pkg::K_OFF;
          written_nxt = 1'b1;
          led_nxt     = 1'b0;
          phase_nxt   = '0;
          bcur_nxt    = (bcur_r < 6'd63) ? bcur_r + 6'd1 : bcur_r;
        end
      end else if (at_end) begin
        if (phase_r >= cfg.code_gap_ms) begin
          ccur_nxt  = ccur_next_code;
          bcur_nxt  = '0;
          phase_nxt = '0;
        end
      end else if (phase_r >= cfg.bit_gap_ms) begin
        kind_nxt    = sleb_pkg::K_BLINK;
        written_nxt = 1'b1;
        led_nxt     = 1'b1;
        phase_nxt   = '0;
      end
    end
    if (cmd.set_state) begin
      chg_en  = 1'b1;
      chg_tgt = ns_r;
    end
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end
    if (cmd.idx_inc) begin
      idx_nxt = CW'(idx_inc1);
    end
    if (cmd.rd_next) begin
      ram_raddr = AW'(idx_inc1);
    end
    if (cmd.wr_total) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(total_r);
      ram_wdata = code_r;
      total_nxt = total_r + CW'(1);
    end
    if (cmd.wr_idx) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(idx_r);
      ram_wdata = ram_rdata;
      idx_nxt   = CW'(idx_inc1);
    end
    if (cmd.dec_total) begin
      total_nxt = total_r - CW'(1);
    end
    if (cmd.fin_deact && (total_r == '0) && (cur_r == sleb_pkg::ST_ERROR)) begin
      chg_en  = 1'b1;
      chg_tgt = sleb_pkg::ST_RUN;
    end
    if (cmd.clear_all) begin
      total_nxt = '0;
      ccur_nxt  = '0;
      bcur_nxt  = '0;
      led_nxt   = 1'b0;
      chg_en    = 1'b1;
      chg_tgt   = sleb_pkg::ST_RUN;
    end
    // State change: ignore unknown or unchanged targets
    if (chg_en && (chg_tgt <= sleb_pkg::ST_WARNING) && (chg_tgt != cur_r)) begin
      cur_nxt     = chg_tgt;
      led_nxt     = 1'b0;
      ccur_nxt    = '0;
      bcur_nxt    = '0;
      phase_nxt   = '0;
      kind_nxt    = state_kind(chg_tgt);
      written_nxt = 1'b1;
    end
    if (cmd.out_load) begin
      out_nxt.color_kind    = kind_r;
      out_nxt.color_written = written_r;
      out_nxt.display_state = cur_r;
      out_nxt.codes_active  = 4'(total_r);
    end
  end

  always_comb begin
    sts.mode         = mode_r;
    sts.code_zero    = (code_r == 8'd0);
    sts.blink_on     = blink_on;
    sts.total_zero   = (total_r == '0);
    sts.idx_at_total = (idx_r == total_r);
    sts.list_full    = (total_r == CW'(ACTIVE_SLOTS));
    sts.rd_match     = (ram_rdata == code_r);
    sts.shift_more   = (idx_inc1 < {1'b0, total_r});
  end

  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r     <= sleb_pkg::ST_OFF;
      led_r     <= 1'b0;
      kind_r    <= sleb_pkg::K_OFF;
      written_r <= 1'b0;
      total_r   <= '0;
      ccur_r    <= '0;
      bcur_r    <= '0;
      phase_r   <= '0;
      toggle_r  <= '0;
      idx_r     <= '0;
    end else begin
      cur_r     <= cur_nxt;
      led_r     <= led_nxt;
      kind_r    <= kind_nxt;
      written_r <= written_nxt;
      total_r   <= total_nxt;
      ccur_r    <= ccur_nxt;
      bcur_r    <= bcur_nxt;
      phase_r   <= phase_nxt;
      toggle_r  <= toggle_nxt;
      idx_r     <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    code_r  <= code_nxt;
    ns_r    <= ns_nxt;
    hit_r   <= hit_nxt;
    pbits_r <= pbits_nxt;
    plen_r  <= plen_nxt;
    out_r   <= out_nxt;
  end

endmodule

// ===== tb/tb_status_led_error_code_blinker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_status_led_error_code_blinker
// Self-checking bench for the status LED error-code blinker. A queue-fed
// driver pushes event items (ticks, state requests, code activate/deactivate,
// clear all) into the block. An item-level model of the LED sequencer
// predicts one result item per event, and a monitor compares each result
// field by field. Timing and pattern registers are rewritten between phases.
// ----------------------------------------------------------------------------
module tb_status_led_error_code_blinker;

  // Unknown mode codes start here; the block must ignore them
  localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
  localparam int NUM_PHASES  = 6;
  localparam int PHASE_ITEMS = 255;
  // Worst single item: deactivate scanning and shifting a full list
  localparam int DRAIN_PAD   = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  sleb_pkg::sleb_in_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  sleb_pkg::sleb_out_t out_data;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  status_led_error_code_blinker DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  // Hard stop in case the handshake hangs
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // LED sequencer model: register copies and sequencer state
  // --------------------------------------------------------------------------
  logic [15:0] short_ms = sleb_pkg::SHORT_PULSE_RST;
  logic [15:0] long_ms  = sleb_pkg::LONG_PULSE_RST;
  logic [15:0] bgap_ms  = sleb_pkg::BIT_GAP_RST;
  logic [15:0] cgap_ms  = sleb_pkg::CODE_GAP_RST;
  logic [46:0] slot_q [4] = '{default: '0};

  logic [2:0]  led_state   = sleb_pkg::ST_OFF;
  logic        led_on      = 1'b0;
  logic [7:0]  code_list [8];
  int          code_count  = 0;
  int          code_idx    = 0;
  int          bit_idx     = 0;
  logic [15:0] phase_ms    = '0;
  logic [15:0] toggle_ms   = '0;
  logic [2:0]  shown_color = sleb_pkg::K_OFF;
  logic        color_wr    = 1'b0;

  sleb_pkg::sleb_in_t  events_pending [$];
  sleb_pkg::sleb_out_t led_results_due [$];

  int errors       = 0;
  int send_idle    = 0;
  int recv_idle    = 0;
  int n_ticks      = 0;
  int n_state_reqs = 0;
  int n_code_evts  = 0;
  int n_checked    = 0;
  int n_blinks     = 0;

  function automatic void show_color(input logic [2:0] kind);
    shown_color = kind;
    color_wr = 1'b1;
  endfunction

  function automatic void change_state(input logic [2:0] s);
    if (s > sleb_pkg::ST_WARNING || s == led_state) return;
    led_state = s;
    led_on    = 1'b0;
    code_idx  = 0;
    bit_idx   = 0;
    phase_ms  = '0;
    case (s)
      sleb_pkg::ST_OFF:   show_color(sleb_pkg::K_OFF);
      sleb_pkg::ST_INIT:  show_color(sleb_pkg::K_INIT);
      sleb_pkg::ST_RUN:   show_color(sleb_pkg::K_RUN);
      sleb_pkg::ST_ERROR: show_color(sleb_pkg::K_OFF);
      default:            show_color(sleb_pkg::K_WARNING);
    endcase
  endfunction

  // Step the code cursor to the next listed code, wrapping at the list end
  function automatic void advance_code();
    code_idx = (code_idx + 1 >= code_count) ? 0 : code_idx + 1;
    bit_idx  = 0;
  endfunction

  function automatic sleb_pkg::sleb_out_t predict_led_result(input sleb_pkg::sleb_in_t ev);
    sleb_pkg::sleb_out_t r;
    logic [31:0] bits;
    int          len;
    bit          found;
    bit          at_end;
    bit          one;
    logic [15:0] dur;
    color_wr = 1'b0;
    case (ev.mode)
      sleb_pkg::MODE_TICK: begin
        if (phase_ms != 16'hFFFF) phase_ms++;
        if (toggle_ms != 16'hFFFF) toggle_ms++;
        if (led_state == sleb_pkg::ST_ERROR ||
            (led_state == sleb_pkg::ST_INIT && code_count > 0)) begin
          if (code_count == 0) begin
            // Plain error: free-running toggle at the short period
            if (toggle_ms >= short_ms) begin
              toggle_ms = '0;
              led_on = !led_on;
              show_color(led_on ? sleb_pkg::K_BLINK : sleb_pkg::K_OFF);
            end
          end else begin
            if (code_idx >= code_count) code_idx = 0;
            found = 1'b0;
            bits = '0;
            len = 0;
            // Lowest valid slot with a matching code wins
            for (int i = 0; i < sleb_pkg::PATTERN_SLOTS; i++) begin
              if (!found && slot_q[i][46] && slot_q[i][7:0] == code_list[code_idx]) begin
                found = 1'b1;
                bits = slot_q[i][45:14];
                len = int'(slot_q[i][13:8]);
                if (len > int'(sleb_pkg::MAX_PATTERN_BITS))
                  len = int'(sleb_pkg::MAX_PATTERN_BITS);
              end
            end
            if (!found) begin
              advance_code();
            end else begin
              at_end = (bit_idx >= len);
              one = !at_end && bits[bit_idx];
              if (led_on) begin
                dur = one ? long_ms : short_ms;
                if (phase_ms >= dur) begin
                  show_color(sleb_pkg::K_OFF);
                  led_on = 1'b0;
                  phase_ms = '0;
                  if (bit_idx < 63) bit_idx++;
                end
              end else if (at_end) begin
                if (phase_ms >= cgap_ms) begin
                  advance_code();
                  phase_ms = '0;
                end
              end else if (phase_ms >= bgap_ms) begin
                show_color(sleb_pkg::K_BLINK);
                led_on = 1'b1;
                phase_ms = '0;
                n_blinks++;
              end
            end
          end
        end
      end
      sleb_pkg::MODE_SET: change_state(ev.new_state);
      sleb_pkg::MODE_ACT: begin
        found = (ev.error_code == 8'd0);
        for (int i = 0; i < code_count; i++)
          if (code_list[i] == ev.error_code) found = 1'b1;
        if (!found && code_count < 8) begin
          code_list[code_count] = ev.error_code;
          code_count++;
        end
      end
      sleb_pkg::MODE_DEACT: begin
        found = 1'b0;
        for (int i = 0; i < code_count; i++) begin
          if (!found && code_list[i] == ev.error_code) begin
            found = 1'b1;
            for (int j = i; j + 1 < code_count; j++) code_list[j] = code_list[j + 1];
          end
        end
        if (found) code_count--;
        if (code_count == 0 && led_state == sleb_pkg::ST_ERROR)
          change_state(sleb_pkg::ST_RUN);
      end
      sleb_pkg::MODE_CLEAR: begin
        code_count = 0;
        code_idx = 0;
        bit_idx = 0;
        led_on = 1'b0;
        change_state(sleb_pkg::ST_RUN);
      end
      default: ;
    endcase
    r.color_kind    = shown_color;
    r.color_written = color_wr;
    r.display_state = led_state;
    r.codes_active  = code_count[3:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present queued items, predict at the accepting edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        led_results_due.push_back(predict_led_result(in_data));
        case (in_data.mode)
          sleb_pkg::MODE_TICK: n_ticks++;
          sleb_pkg::MODE_SET:  n_state_reqs++;
          default:             n_code_evts++;
        endcase
      end
      // Hold the current item until it is taken; otherwise pick the next or idle
      if (!in_valid || in_ready) begin
        if (events_pending.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          in_data  <= events_pending.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random back-pressure, compare each taken result item
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    sleb_pkg::sleb_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (led_results_due.size() == 0) begin
          $display("%0t: unexpected result item %h", $time, out_data);
          errors++;
        end else begin
          want = led_results_due.pop_front();
          n_checked++;
          if (out_data.color_kind !== want.color_kind) begin
            $display("%0t: color_kind expected %0d got %0d", $time,
                     want.color_kind, out_data.color_kind);
            errors++;
          end
          if (out_data.color_written !== want.color_written) begin
            $display("%0t: color_written expected %0d got %0d", $time,
                     want.color_written, out_data.color_written);
            errors++;
          end
          if (out_data.display_state !== want.display_state) begin
            $display("%0t: display_state expected %0d got %0d", $time,
                     want.display_state, out_data.display_state);
            errors++;
          end
          if (out_data.codes_active !== want.codes_active) begin
            $display("%0t: codes_active expected %0d got %0d", $time,
                     want.codes_active, out_data.codes_active);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Two-phase APB write; the register lands on the access edge with pready high
  task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      sleb_pkg::REG_SHORT_PULSE: short_ms = val[15:0];
      sleb_pkg::REG_LONG_PULSE:  long_ms  = val[15:0];
      sleb_pkg::REG_BIT_GAP:     bgap_ms  = val[15:0];
      sleb_pkg::REG_CODE_GAP:    cgap_ms  = val[15:0];
      default:                   slot_q[idx - sleb_pkg::REG_SLOT_A] = val[46:0];
    endcase
  endtask

  // Block until every item is taken and answered, then let the block settle
  task automatic wait_drained();
    while (events_pending.size() != 0 || in_valid || led_results_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  function automatic sleb_pkg::sleb_in_t mk_event(input logic [2:0] m,
                                                  input logic [7:0] c,
                                                  input logic [2:0] s);
    sleb_pkg::sleb_in_t ev;
    ev.mode = m;
    ev.error_code = c;
    ev.new_state = s;
    return ev;
  endfunction

  function automatic logic [63:0] mk_slot(input logic vld, input logic [31:0] bits,
                                          input logic [5:0] len, input logic [7:0] code);
    return {17'd0, vld, bits, len, code};
  endfunction

  // Codes mostly from a pool of nine, so lists fill up and slots match
  function automatic logic [7:0] pick_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return 8'd0;
    if (r < 16) return 8'($urandom_range(0, 255));
    if (r < 20) return 8'd255;
    return 8'($urandom_range(1, 9));
  endfunction

  function automatic logic [63:0] random_slot();
    int          r;
    logic [5:0]  len;
    logic [7:0]  code;
    r = $urandom_range(0, 99);
    // Short patterns complete quickly; a few overlong ones get clamped
    if (r < 75)      len = 6'($urandom_range(0, 5));
    else if (r < 90) len = 6'($urandom_range(6, 32));
    else             len = 6'($urandom_range(33, 63));
    code = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(1, 9));
    return mk_slot($urandom_range(0, 99) < 85, $urandom, len, code);
  endfunction

  // Mostly ticks, state requests leaning to error or init; fields are noise otherwise
  function automatic sleb_pkg::sleb_in_t random_event();
    sleb_pkg::sleb_in_t ev;
    int                 r;
    ev.mode = sleb_pkg::MODE_TICK;
    ev.error_code = 8'($urandom_range(0, 255));
    ev.new_state = 3'($urandom_range(0, 7));
    r = $urandom_range(0, 99);
    if (r < 60) begin
      ev.mode = sleb_pkg::MODE_TICK;
    end else if (r < 72) begin
      ev.mode = sleb_pkg::MODE_SET;
      r = $urandom_range(0, 99);
      if (r < 40)      ev.new_state = sleb_pkg::ST_ERROR;
      else if (r < 70) ev.new_state = sleb_pkg::ST_INIT;
    end else if (r < 86) begin
      ev.mode = sleb_pkg::MODE_ACT;
      ev.error_code = pick_code();
    end else if (r < 95) begin
      ev.mode = sleb_pkg::MODE_DEACT;
      ev.error_code = pick_code();
    end else if (r < 97) begin
      ev.mode = sleb_pkg::MODE_CLEAR;
    end else begin
      ev.mode = 3'($urandom_range(MODE_UNUSED_FIRST, 7));
    end
    return ev;
  endfunction

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [15:0] t [4];
    int          half;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: fast timings so patterns run within a few ticks.
    // Slot c duplicates slot a's code and must lose; slot d is invalid.
    send_idle = 22;
    recv_idle = 56;
    reg_write(sleb_pkg::REG_SHORT_PULSE, 64'd2);
    reg_write(sleb_pkg::REG_LONG_PULSE,  64'd3);
    reg_write(sleb_pkg::REG_BIT_GAP,     64'd1);
    reg_write(sleb_pkg::REG_CODE_GAP,    64'd2);
    reg_write(sleb_pkg::REG_SLOT_A, mk_slot(1'b1, 32'h0000_0005, 6'd3, 8'd5));
    reg_write(sleb_pkg::REG_SLOT_B, mk_slot(1'b1, 32'hFFFF_FFFF, 6'd63, 8'd255));
    reg_write(sleb_pkg::REG_SLOT_C, mk_slot(1'b1, 32'h0000_0000, 6'd1, 8'd5));
    reg_write(sleb_pkg::REG_SLOT_D, mk_slot(1'b0, 32'h0000_0001, 6'd1, 8'd9));

    events_pending.push_back(mk_event(sleb_pkg::MODE_TICK, 8'hFF, 3'd7));
    // unknown state
    events_pending.push_back(mk_event(sleb_pkg::MODE_SET, 8'd0, 3'd7));
    // unknown mode
    events_pending.push_back(mk_event(3'd7, 8'hFF, 3'd7));
    // same state
    events_pending.push_back(mk_event(sleb_pkg::MODE_SET, 8'd0, sleb_pkg::ST_OFF));
    // code zero
    events_pending.push_back(mk_event(sleb_pkg::MODE_ACT, 8'd0, sleb_pkg::ST_OFF));
    events_pending.push_back(mk_event(sleb_pkg::MODE_ACT, 8'd5, sleb_pkg::ST_OFF));
    // duplicate
    events_pending.push_back(mk_event(sleb_pkg::MODE_ACT, 8'd5, sleb_pkg::ST_OFF));
    // no pattern slot
    events_pending.push_back(mk_event(sleb_pkg::MODE_ACT, 8'd9, sleb_pkg::ST_OFF));
    // clamped length
    events_pending.push_back(mk_event(sleb_pkg::MODE_ACT, 8'd255, sleb_pkg::ST_OFF));
    events_pending.push_back(mk_event(sleb_pkg::MODE_SET, 8'd0, sleb_pkg::ST_INIT));
    repeat (6)
      events_pending.push_back(mk_event(sleb_pkg::MODE_TICK, 8'd0, sleb_pkg::ST_OFF));
    events_pending.push_back(mk_event(sleb_pkg::MODE_SET, 8'd0, sleb_pkg::ST_ERROR));
    // absent code
    events_pending.push_back(mk_event(sleb_pkg::MODE_DEACT, 8'd200, sleb_pkg::ST_OFF));
    events_pending.push_back(mk_event(sleb_pkg::MODE_DEACT, 8'd5, sleb_pkg::ST_OFF));
    events_pending.push_back(mk_event(sleb_pkg::MODE_DEACT, 8'd9, sleb_pkg::ST_OFF));
    // empty: to run
    events_pending.push_back(mk_event(sleb_pkg::MODE_DEACT, 8'd255, sleb_pkg::ST_OFF));
    events_pending.push_back(mk_event(sleb_pkg::MODE_SET, 8'd0, sleb_pkg::ST_ERROR));
    repeat (3)
      events_pending.push_back(mk_event(sleb_pkg::MODE_TICK, 8'd0, sleb_pkg::ST_OFF));
    events_pending.push_back(mk_event(sleb_pkg::MODE_CLEAR, 8'd0, sleb_pkg::ST_OFF));
    events_pending.push_back(mk_event(sleb_pkg::MODE_SET, 8'd0, sleb_pkg::ST_WARNING));
    wait_drained();

    // Random phases: timing and pattern table change only while idle; the
    // sequencer state carries over, so a pattern may shrink under the cursor
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph / 2)
        0: begin send_idle = 22; recv_idle = 56; end
        1: begin send_idle = 56; recv_idle = 22; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (int i = 0; i < 4; i++) begin
        case (ph)
          0:       t[i] = 16'd1;
          1:       t[i] = 16'($urandom_range(1, 4));
          2:       t[i] = 16'hFFFF;
          3:       t[i] = 16'($urandom_range(1, 6));
          4:       t[i] = 16'($urandom_range(1, 3));
          default: t[i] = 16'($urandom_range(1, 8));
        endcase
      end
      reg_write(sleb_pkg::REG_SHORT_PULSE, {48'd0, t[0]});
      reg_write(sleb_pkg::REG_LONG_PULSE,  {48'd0, t[1]});
      reg_write(sleb_pkg::REG_BIT_GAP,     {48'd0, t[2]});
      reg_write(sleb_pkg::REG_CODE_GAP,    {48'd0, t[3]});
      reg_write(sleb_pkg::REG_SLOT_A, random_slot());
      reg_write(sleb_pkg::REG_SLOT_B, random_slot());
      reg_write(sleb_pkg::REG_SLOT_C, random_slot());
      reg_write(sleb_pkg::REG_SLOT_D, random_slot());

      half = PHASE_ITEMS / 2;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Starve the block once mid-phase until every result is back
        if (ph == 4 && k == half) wait_drained();
        events_pending.push_back(random_event());
      end
      wait_drained();
    end

    $display("Covered %0d ticks, %0d state requests, %0d code events; %0d blink pulses",
             n_ticks, n_state_reqs, n_code_evts, n_blinks);
    $display("Compared %0d result items over %0d register settings",
             n_checked, NUM_PHASES + 1);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
